### sv/trhd_pkg.sv
package trhd_pkg;

    localparam int unsigned REC_LEN_W = 16;
    localparam int unsigned MSG_LEN_W = 24;
    localparam int unsigned CFG_DATA_W = 24;

    localparam logic [REC_LEN_W-1:0] RESET_MAX_RECORD = REC_LEN_W'(18432);
    localparam logic [MSG_LEN_W-1:0] RESET_MAX_MESSAGE = MSG_LEN_W'(18432);

    localparam logic [7:0] TYPE_HANDSHAKE = 8'd22;

    // Record header positions; the highest value, REC_POS_PAYLOAD, means inside the payload.
    localparam logic [2:0] REC_POS_LEN_LO = 3'd4;
    localparam logic [2:0] REC_POS_PAYLOAD = 3'd5;
    localparam logic [2:0] REC_POS_LEN_HI = 3'd3;
    localparam logic [2:0] REC_POS_TYPE = 3'd0;

    // Handshake header positions; the last value means inside the body.
    localparam logic [2:0] MSG_POS_TYPE = 3'd0;
    localparam logic [2:0] MSG_POS_LEN_LO = 3'd3;
    localparam logic [2:0] MSG_POS_BODY = 3'd4;

    typedef enum logic [2:0] {
        KIND_HS_BYTE     = 3'd0,
        KIND_HS_EMPTY    = 3'd1,
        KIND_OTHER_BYTE  = 3'd2,
        KIND_OTHER_EMPTY = 3'd3,
        KIND_ERROR       = 3'd4
    } t_kind;

    typedef enum logic {
        ERR_RECORD_LONG  = 1'b0,
        ERR_MESSAGE_LONG = 1'b1
    } t_err_code;

    typedef enum logic {
        CFG_MAX_RECORD  = 1'b0,
        CFG_MAX_MESSAGE = 1'b1
    } t_cfg_index;

    // Record layer decision for one byte.
    typedef struct packed {
        logic hs_byte;      // payload byte of a handshake record
        logic other_byte;   // payload byte of another record type
        logic empty_other;  // empty non-handshake record
        logic rec_err;      // record longer than the limit
        logic first;
        logic last;
    } t_rec_evt;

    // Handshake layer decision for one byte.
    typedef struct packed {
        logic body_byte;
        logic empty_msg;
        logic msg_err;
        logic first;
        logic last;
    } t_msg_evt;

endpackage

### sv/trhd_record.sv
module trhd_record (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_step,
    input  logic [7:0]                      i_byte,
    input  logic [trhd_pkg::REC_LEN_W-1:0]  i_max_record_length,
    output trhd_pkg::t_rec_evt              o_evt,
    output logic [7:0]                      o_record_type
);

    logic [2:0]                     r_pos, n_pos;
    logic [7:0]                     r_type, n_type;
    logic [7:0]                     r_len_hi, n_len_hi;
    logic [trhd_pkg::REC_LEN_W-1:0] r_left, n_left;
    logic                           r_other_started, n_other_started;
    logic [trhd_pkg::REC_LEN_W-1:0] w_len;
    logic [trhd_pkg::REC_LEN_W-1:0] w_left_dec;
    logic                           w_is_hs;

    assign w_len      = {r_len_hi, i_byte};
    assign w_left_dec = (r_left != '0) ? r_left - trhd_pkg::REC_LEN_W'(1) : '0;
    assign w_is_hs    = (r_type == trhd_pkg::TYPE_HANDSHAKE);

    always_comb begin
        n_pos           = r_pos;
        n_type          = r_type;
        n_len_hi        = r_len_hi;
        n_left          = r_left;
        n_other_started = r_other_started;
        o_evt           = '0;
        if (r_pos != trhd_pkg::REC_POS_PAYLOAD) begin
            if (r_pos == trhd_pkg::REC_POS_TYPE) begin
                n_type = i_byte;
            end
            if (r_pos == trhd_pkg::REC_POS_LEN_HI) begin
                n_len_hi = i_byte;
            end
            n_pos = r_pos + 3'd1;
            if (r_pos == trhd_pkg::REC_POS_LEN_LO) begin
                if (w_len > i_max_record_length) begin
                    o_evt.rec_err = 1'b1;
                end else if (w_len == '0) begin
                    n_pos = trhd_pkg::REC_POS_TYPE;
                    if (!w_is_hs) begin
                        o_evt.empty_other = 1'b1;
                        o_evt.first       = 1'b1;
                        o_evt.last        = 1'b1;
                    end
                end else begin
                    n_left          = w_len;
                    n_other_started = 1'b0;
                end
            end
        end else begin
            n_left = w_left_dec;
            if (w_left_dec == '0) begin
                n_pos = trhd_pkg::REC_POS_TYPE;
            end
            if (w_is_hs) begin
                o_evt.hs_byte = 1'b1;
            end else begin
                o_evt.other_byte = 1'b1;
                o_evt.first      = !r_other_started;
                o_evt.last       = (w_left_dec == '0);
                n_other_started  = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos           <= trhd_pkg::REC_POS_TYPE;
            r_other_started <= 1'b0;
            r_left          <= '0;
        end else if (i_step) begin
            r_pos           <= n_pos;
            r_other_started <= n_other_started;
            r_left          <= n_left;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_type   <= n_type;
            r_len_hi <= n_len_hi;
        end
    end

    // The type register is loaded by the first header byte, before any beat that carries it.
    assign o_record_type = r_type;

endmodule

### sv/trhd_message.sv
module trhd_message (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_step,
    input  logic [7:0]                      i_byte,
    input  logic [trhd_pkg::MSG_LEN_W-1:0]  i_max_message_length,
    output trhd_pkg::t_msg_evt              o_evt,
    output logic [7:0]                      o_message_type
);

    logic [2:0]                     r_pos, n_pos;
    logic [7:0]                     r_mtype, n_mtype;
    logic [trhd_pkg::MSG_LEN_W-1:0] r_collect, n_collect;
    logic [trhd_pkg::MSG_LEN_W-1:0] r_left, n_left;
    logic                           r_started, n_started;
    logic [trhd_pkg::MSG_LEN_W-1:0] w_left_dec;

    assign w_left_dec = (r_left != '0) ? r_left - trhd_pkg::MSG_LEN_W'(1) : '0;

    always_comb begin
        n_pos     = r_pos;
        n_mtype   = r_mtype;
        n_collect = r_collect;
        n_left    = r_left;
        n_started = r_started;
        o_evt     = '0;
        if (r_pos != trhd_pkg::MSG_POS_BODY) begin
            if (r_pos == trhd_pkg::MSG_POS_TYPE) begin
                n_mtype   = i_byte;
                n_collect = '0;
            end else begin
                n_collect = {r_collect[trhd_pkg::MSG_LEN_W-9:0], i_byte};
            end
            n_pos = r_pos + 3'd1;
            if (r_pos == trhd_pkg::MSG_POS_LEN_LO) begin
                if (n_collect > i_max_message_length) begin
                    o_evt.msg_err = 1'b1;
                end else if (n_collect == '0) begin
                    n_pos           = trhd_pkg::MSG_POS_TYPE;
                    o_evt.empty_msg = 1'b1;
                    o_evt.first     = 1'b1;
                    o_evt.last      = 1'b1;
                end else begin
                    n_left    = n_collect;
                    n_started = 1'b0;
                end
            end
        end else begin
            o_evt.body_byte = 1'b1;
            o_evt.first     = !r_started;
            o_evt.last      = (r_left <= trhd_pkg::MSG_LEN_W'(1));
            n_started       = 1'b1;
            n_left          = w_left_dec;
            if (w_left_dec == '0) begin
                n_pos = trhd_pkg::MSG_POS_TYPE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= trhd_pkg::MSG_POS_TYPE;
            r_started <= 1'b0;
            r_left    <= '0;
        end else if (i_step) begin
            r_pos     <= n_pos;
            r_started <= n_started;
            r_left    <= n_left;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_mtype   <= n_mtype;
            r_collect <= n_collect;
        end
    end

    assign o_message_type = r_mtype;

endmodule

### sv/tls_record_handshake_deframer_core.sv
// Path: an accepted byte is held in the input register; its result beat, if any, is
// registered from there and shown on the outputs (input register, then result register).
// Throughput: one stream byte per cycle while no result beat stalls; a stalled beat holds
// the input register, and the result register is refilled in the cycle it is taken.
// Reset: synchronous, active low; clears parser state, the sticky error and both
// valid flags, and returns both length limits to 18432.
module tls_record_handshake_deframer_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_wr_en,
    input  logic                            i_cfg_index,
    input  logic [trhd_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [7:0]                      s_axis_tdata,   // [7:0] stream_byte
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [7:0] content_type, [15:8] message_type, [23:16] payload_byte
    output logic [23:0]                     m_axis_tdata,
    // [2:0] kind, [3] first_of_unit, [4] error_code
    output logic [4:0]                      m_axis_tuser,
    output logic                            m_axis_tlast    // last_of_unit
);

    logic [trhd_pkg::REC_LEN_W-1:0] r_max_record;
    logic [trhd_pkg::MSG_LEN_W-1:0] r_max_message;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_error;

    logic       r_out_valid;
    logic [2:0] r_out_kind;
    logic [7:0] r_out_ctype;
    logic [7:0] r_out_mtype;
    logic [7:0] r_out_byte;
    logic       r_out_first;
    logic       r_out_last;
    logic       r_out_code;

    logic               w_proc;
    logic               w_step;
    trhd_pkg::t_rec_evt w_rec;
    trhd_pkg::t_msg_evt w_msg;
    logic [7:0]         w_rec_type;
    logic [7:0]         w_msg_type;

    logic       n_has;
    logic [2:0] n_kind;
    logic [7:0] n_mtype;
    logic [7:0] n_byte;
    logic       n_first;
    logic       n_last;
    logic       n_code;

    assign w_proc        = r_in_valid && (!r_out_valid || m_axis_tready);
    assign w_step        = w_proc && !r_error;
    assign s_axis_tready = !r_in_valid || w_proc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_record  <= trhd_pkg::RESET_MAX_RECORD;
            r_max_message <= trhd_pkg::RESET_MAX_MESSAGE;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                trhd_pkg::CFG_MAX_RECORD: begin
                    r_max_record <= i_cfg_wdata[trhd_pkg::REC_LEN_W-1:0];
                end
                trhd_pkg::CFG_MAX_MESSAGE: begin
                    r_max_message <= i_cfg_wdata[trhd_pkg::MSG_LEN_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_byte <= s_axis_tdata;
        end
    end

    trhd_record u_record (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_step              (w_step),
        .i_byte              (r_in_byte),
        .i_max_record_length (r_max_record),
        .o_evt               (w_rec),
        .o_record_type       (w_rec_type)
    );

    trhd_message u_message (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_step               (w_step && w_rec.hs_byte),
        .i_byte               (r_in_byte),
        .i_max_message_length (r_max_message),
        .o_evt                (w_msg),
        .o_message_type       (w_msg_type)
    );

    always_comb begin
        n_has   = 1'b0;
        n_kind  = trhd_pkg::KIND_ERROR;
        n_mtype = '0;
        n_byte  = '0;
        n_first = 1'b0;
        n_last  = 1'b0;
        n_code  = trhd_pkg::ERR_RECORD_LONG;
        if (w_rec.rec_err) begin
            n_has = 1'b1;
        end else if (w_rec.empty_other) begin
            n_has   = 1'b1;
            n_kind  = trhd_pkg::KIND_OTHER_EMPTY;
            n_first = 1'b1;
            n_last  = 1'b1;
        end else if (w_rec.other_byte) begin
            n_has   = 1'b1;
            n_kind  = trhd_pkg::KIND_OTHER_BYTE;
            n_byte  = r_in_byte;
            n_first = w_rec.first;
            n_last  = w_rec.last;
        end else if (w_rec.hs_byte) begin
            if (w_msg.msg_err) begin
                n_has  = 1'b1;
                n_code = trhd_pkg::ERR_MESSAGE_LONG;
            end else if (w_msg.empty_msg) begin
                n_has   = 1'b1;
                n_kind  = trhd_pkg::KIND_HS_EMPTY;
                n_mtype = w_msg_type;
                n_first = 1'b1;
                n_last  = 1'b1;
            end else if (w_msg.body_byte) begin
                n_has   = 1'b1;
                n_kind  = trhd_pkg::KIND_HS_BYTE;
                n_mtype = w_msg_type;
                n_byte  = r_in_byte;
                n_first = w_msg.first;
                n_last  = w_msg.last;
            end
        end
    end

    // Once an error is reported, every later byte is dropped until reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_error     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_step && (w_rec.rec_err || (w_rec.hs_byte && w_msg.msg_err))) begin
                r_error <= 1'b1;
            end
            if (w_proc) begin
                r_out_valid <= w_step && n_has;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step && n_has) begin
            r_out_kind  <= n_kind;
            r_out_ctype <= w_rec_type;
            r_out_mtype <= n_mtype;
            r_out_byte  <= n_byte;
            r_out_first <= n_first;
            r_out_last  <= n_last;
            r_out_code  <= n_code;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_byte, r_out_mtype, r_out_ctype};
    assign m_axis_tuser  = {r_out_code, r_out_first, r_out_kind};
    assign m_axis_tlast  = r_out_last;

endmodule
